FILE: rtl/core/rmt_pkg.sv
// ----------------------------------------------------------------------------
// rmt_pkg
// Shared constants and types for the running median tracker.
// ----------------------------------------------------------------------------
package rmt_pkg;

    localparam int Capacity    = 1024;
    localparam int SampleWidth = 16;
    localparam int HeapDepth   = Capacity / 2 + 1;
    localparam int AddrWidth   = $clog2(HeapDepth);
    localparam int CountWidth  = $clog2(Capacity + 1);
    localparam int HalfWidth   = $clog2(HeapDepth + 1);
    localparam int MedWidth    = SampleWidth + 1;

    typedef logic signed [SampleWidth-1:0] sample_t;
    typedef logic [AddrWidth-1:0]          addr_t;
    typedef logic [HalfWidth-1:0]          half_t;

    // Command from the sequencer to one heap engine
    typedef enum logic [1:0] {
        HOP_PUSH = 2'b01,
        HOP_POP  = 2'b10
    } heap_op_t;

    typedef struct packed {
        logic     start;
        heap_op_t op;
        sample_t  value;
    } heap_cmd_t;

    typedef struct packed {
        logic    busy;
        sample_t top;
        sample_t popped;
        half_t   count;
    } heap_stat_t;

endpackage

FILE: rtl/core/running_median_tracker_core.sv
// Steps: a rejected sample goes straight to the output; otherwise a push,
//   then at most a pop and a push to rebalance the two halves.
// Flow: one item at a time; s_tready is high only while idle, and a finished
//   item waits until the output register is free.
// Reset: aresetn synchronous active low clears both heap counts; heap
//   memories are not cleared, only entries below the counts are read.
// ----------------------------------------------------------------------------
// running_median_tracker_core
// Two-heap running median: insert (or flag overflow when full), rebalance, report twice the median.
// ----------------------------------------------------------------------------
module running_median_tracker_core import rmt_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] sample
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [16:0] median_times_two, [27:17] sample_count,
                                   // [28] overflow, [31:29] zero
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_INS   = 7'b0000010,
        S_INSW  = 7'b0000100,
        S_BAL   = 7'b0001000,
        S_POPW  = 7'b0010000,
        S_PUSHW = 7'b0100000,
        S_OUT   = 7'b1000000
    } st_t;

    st_t        state_reg, state_next;
    heap_cmd_t  lo_cmd, hi_cmd;
    heap_stat_t lo_st, hi_st;
    sample_t    samp_reg, samp_next;
    logic       ovf_reg, ovf_next;
    logic       dir_reg, dir_next;     // 1: move lower top to upper
    logic       mvalid_reg;
    logic [31:0] mdata_reg;
    logic [MedWidth-1:0]   med;
    logic [CountWidth-1:0] total;
    logic       lo_busy, hi_busy;

    rmt_heap u_lo (.aclk, .aresetn, .is_max(1'b1), .cmd(lo_cmd), .stat(lo_st));
    rmt_heap u_hi (.aclk, .aresetn, .is_max(1'b0), .cmd(hi_cmd), .stat(hi_st));

    assign lo_busy = lo_st.busy;
    assign hi_busy = hi_st.busy;
    assign total   = CountWidth'(lo_st.count) + CountWidth'(hi_st.count);

    // Twice the median from the tops
    always_comb begin
        if (lo_st.count == '0) begin
            med = '0;
        end else if (lo_st.count == hi_st.count) begin
            med = MedWidth'(lo_st.top) + MedWidth'(hi_st.top);
        end else begin
            med = {lo_st.top, 1'b0};
        end
    end

    always_comb begin
        state_next = state_reg;
        samp_next  = samp_reg;
        ovf_next   = ovf_reg;
        dir_next   = dir_reg;
        lo_cmd     = '{start: 1'b0, op: HOP_PUSH, value: samp_reg};
        hi_cmd     = '{start: 1'b0, op: HOP_PUSH, value: samp_reg};
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    samp_next  = s_tdata;
                    ovf_next   = (total >= CountWidth'(Capacity));
                    state_next = (total >= CountWidth'(Capacity)) ? S_OUT : S_INS;
                end
            end
            // Pick the half and push
            S_INS: begin
                if (lo_st.count == '0 || samp_reg <= lo_st.top) begin
                    lo_cmd.start = 1'b1;
                end else begin
                    hi_cmd.start = 1'b1;
                end
                state_next = S_INSW;
            end
            S_INSW: begin
                if (!lo_busy && !hi_busy) begin
                    state_next = S_BAL;
                end
            end
            // Rebalance, if needed, by one pop and one push
            S_BAL: begin
                if (lo_st.count > hi_st.count + half_t'(1)) begin
                    lo_cmd.start = 1'b1;
                    lo_cmd.op    = HOP_POP;
                    dir_next     = 1'b1;
                    state_next   = S_POPW;
                end else if (hi_st.count > lo_st.count) begin
                    hi_cmd.start = 1'b1;
                    hi_cmd.op    = HOP_POP;
                    dir_next     = 1'b0;
                    state_next   = S_POPW;
                end else begin
                    state_next = S_OUT;
                end
            end
            S_POPW: begin
                if (!lo_busy && !hi_busy) begin
                    if (dir_reg) begin
                        hi_cmd.start = 1'b1;
                        hi_cmd.value = lo_st.popped;
                    end else begin
                        lo_cmd.start = 1'b1;
                        lo_cmd.value = hi_st.popped;
                    end
                    state_next = S_PUSHW;
                end
            end
            S_PUSHW: begin
                if (!lo_busy && !hi_busy) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (!mvalid_reg) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_OUT && !mvalid_reg) begin
                mvalid_reg <= 1'b1;
            end else if (m_tready) begin
                mvalid_reg <= 1'b0;
            end
        end
        samp_reg <= samp_next;
        ovf_reg  <= ovf_next;
        dir_reg  <= dir_next;
        if (state_reg == S_OUT && !mvalid_reg) begin
            mdata_reg <= {3'b000, ovf_reg, total, med};
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;

endmodule

FILE: rtl/core/rmt_heap.sv
// ----------------------------------------------------------------------------
// rmt_heap
// One binary heap in a memory with one write and one read port, sifted one level at a time by a
// shared compare unit. Max-heap when is_max is high, min-heap otherwise.
// ----------------------------------------------------------------------------
module rmt_heap import rmt_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       is_max,
    input  heap_cmd_t  cmd,
    output heap_stat_t stat
);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_UPRD  = 9'b000000010,
        ST_UPCMP = 9'b000000100,
        ST_UPWR  = 9'b000001000,
        ST_LRD   = 9'b000010000,
        ST_LCMP  = 9'b000100000,
        ST_RCMP  = 9'b001000000,
        ST_DNWR  = 9'b010000000,
        ST_POPRD = 9'b100000000
    } hst_t;

    sample_t mem [HeapDepth];
    sample_t rdata_reg;

    hst_t    state_reg, state_next;
    half_t   count_reg, count_next;
    addr_t   idx_reg, idx_next;       // current position of the moving value
    addr_t   best_reg, best_next;     // child chosen on the way down
    sample_t val_reg, val_next;       // value being sifted
    sample_t bval_reg, bval_next;     // value at best child
    sample_t top_reg, top_next;
    sample_t pop_reg, pop_next;

    logic    we;
    addr_t   waddr, raddr;
    sample_t wdata;

    logic [HalfWidth:0] lchild, rchild;
    addr_t   parent;
    logic    cmp_a_above_b;
    sample_t cmp_a, cmp_b;

    assign parent = (idx_reg - addr_t'(1)) >> 1;
    assign lchild = {idx_reg, 1'b1};
    assign rchild = lchild + (HalfWidth+1)'(1);

    // Shared compare unit
    always_comb begin
        cmp_a_above_b = is_max ? (cmp_a > cmp_b) : (cmp_a < cmp_b);
    end

    // Memory: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        best_next  = best_reg;
        val_next   = val_reg;
        bval_next  = bval_reg;
        top_next   = top_reg;
        pop_next   = pop_reg;
        we         = 1'b0;
        waddr      = idx_reg;
        wdata      = val_reg;
        raddr      = parent;
        cmp_a      = val_reg;
        cmp_b      = rdata_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.start && cmd.op == HOP_PUSH) begin
                    val_next   = cmd.value;
                    idx_next   = addr_t'(count_reg);
                    count_next = count_reg + half_t'(1);
                    if (count_reg == '0) begin
                        we        = 1'b1;
                        waddr     = '0;
                        wdata     = cmd.value;
                        top_next  = cmd.value;
                    end else begin
                        state_next = ST_UPRD;
                    end
                end else if (cmd.start && cmd.op == HOP_POP) begin
                    pop_next   = top_reg;
                    count_next = count_reg - half_t'(1);
                    raddr      = addr_t'(count_reg - half_t'(1));
                    idx_next   = '0;
                    if (count_reg > half_t'(1)) begin
                        state_next = ST_POPRD;
                    end
                end
            end
            // Issue parent read
            ST_UPRD: begin
                raddr      = parent;
                state_next = ST_UPCMP;
            end
            // Move parent down or place value
            ST_UPCMP: begin
                if (cmp_a_above_b) begin
                    we       = 1'b1;
                    waddr    = idx_reg;
                    wdata    = rdata_reg;
                    idx_next = parent;
                    if (parent == '0) begin
                        state_next = ST_UPWR;
                    end else begin
                        state_next = ST_UPRD;
                    end
                end else begin
                    state_next = ST_UPWR;
                end
            end
            ST_UPWR: begin
                we         = 1'b1;
                waddr      = idx_reg;
                wdata      = val_reg;
                if (idx_reg == '0) begin
                    top_next = val_reg;
                end
                state_next = ST_IDLE;
            end
            // Last entry read, becomes the moving value at the root
            ST_POPRD: begin
                val_next   = rdata_reg;
                state_next = ST_LRD;
                raddr      = addr_t'(lchild);
            end
            // Issue left child read (or finish)
            ST_LRD: begin
                raddr = addr_t'(lchild);
                if (lchild >= (HalfWidth+1)'(count_reg)) begin
                    state_next = ST_DNWR;
                end else begin
                    state_next = ST_LCMP;
                end
            end
            ST_LCMP: begin
                cmp_a     = rdata_reg;
                cmp_b     = val_reg;
                best_next = idx_reg;
                bval_next = val_reg;
                if (cmp_a_above_b) begin
                    best_next = addr_t'(lchild);
                    bval_next = rdata_reg;
                end
                raddr = addr_t'(rchild);
                if (rchild >= (HalfWidth+1)'(count_reg)) begin
                    if (cmp_a_above_b) begin
                        we       = 1'b1;
                        waddr    = idx_reg;
                        wdata    = rdata_reg;
                        idx_next = addr_t'(lchild);
                        if (idx_reg == '0) begin
                            top_next = rdata_reg;
                        end
                    end
                    state_next = ST_DNWR;
                end else begin
                    state_next = ST_RCMP;
                end
            end
            ST_RCMP: begin
                cmp_a = rdata_reg;
                cmp_b = bval_reg;
                if (cmp_a_above_b || best_reg != idx_reg) begin
                    we    = 1'b1;
                    waddr = idx_reg;
                    if (cmp_a_above_b) begin
                        wdata    = rdata_reg;
                        idx_next = addr_t'(rchild);
                    end else begin
                        wdata    = bval_reg;
                        idx_next = best_reg;
                    end
                    if (idx_reg == '0) begin
                        top_next = wdata;
                    end
                    state_next = ST_LRD;
                end else begin
                    state_next = ST_DNWR;
                end
            end
            ST_DNWR: begin
                we         = 1'b1;
                waddr      = idx_reg;
                wdata      = val_reg;
                if (idx_reg == '0) begin
                    top_next = val_reg;
                end
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
        idx_reg  <= idx_next;
        best_reg <= best_next;
        val_reg  <= val_next;
        bval_reg <= bval_next;
        top_reg  <= top_next;
        pop_reg  <= pop_next;
    end

    assign stat.busy   = (state_reg != ST_IDLE);
    assign stat.top    = top_reg;
    assign stat.popped = pop_reg;
    assign stat.count  = count_reg;

endmodule

FILE: rtl/core/rmt_checker.sv
// ----------------------------------------------------------------------------
// rmt_checker
// Port-level checks on the running median tracker.
// ----------------------------------------------------------------------------
module rmt_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // Hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed under stall");

    // Take no item while one is in flight
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready right after accept");

    // Count never exceeds capacity
    a_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[27:17] <= 11'd1024)
        else $error("count over capacity");

    // Overflow only at full store
    a_ovf: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[28] |-> m_tdata[27:17] == 11'd1024)
        else $error("overflow below capacity");

endmodule

bind running_median_tracker_core rmt_checker u_rmt_checker (.*);
